@@ rtl/core/ordered_value_list_assert.svh @@
// Assertion macros used by the port-level checker of the ordered value list
`ifndef ORDERED_VALUE_LIST_ASSERT_SVH
`define ORDERED_VALUE_LIST_ASSERT_SVH

// Check a property on every rising clock edge outside reset
`define OVL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication that must hold from the edge after the trigger
`define OVL_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    `OVL_ASSERT(lbl, clk, rst_n, (trig) |=> (cons), msg)

`endif

@@ rtl/core/ovl_pkg.sv @@
// Package with the types and codes of the ordered value list
`timescale 1ns / 1ps
`default_nettype none

package ovl_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        OP_APPEND   = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_READ     = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic valid;    // cell holds a live entry
        logic cap;      // capture the compare against the incoming word
        logic load;     // store the incoming value (append at tail)
        logic shift;    // take the neighbor value if a match lies at or before
        logic rd_sel;   // drive the stored value onto the read bus
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ rtl/core/ovl_cell.sv @@
// One storage cell of the ordered value list with compare and shift
`timescale 1ns / 1ps
`default_nettype none

module ovl_cell (
    input  wire                             i_clk,
    input  ovl_pkg::t_cell_ctl              i_ctl,
    input  wire [ovl_pkg::VALUE_W-1:0]      i_value,      // broadcast value
    input  wire [ovl_pkg::VALUE_W-1:0]      i_next_value, // neighbor toward tail
    input  wire                             i_hit,        // match seen before this cell
    output logic [ovl_pkg::VALUE_W-1:0]     o_value,
    output logic [ovl_pkg::VALUE_W-1:0]     o_rd_value,
    output logic                            o_hit
);

    logic [ovl_pkg::VALUE_W-1:0] r_value;
    logic                        r_match;

    // Hold the compare result of the incoming word
    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_match <= i_ctl.valid && (r_value == i_value);
        end
    end

    // Load on append, close the gap on remove
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_value <= i_value;
        end else if (i_ctl.shift && (i_hit || r_match)) begin
            r_value <= i_next_value;
        end
    end

    assign o_value    = r_value;
    assign o_hit      = i_hit || r_match;
    assign o_rd_value = i_ctl.rd_sel ? r_value : '0;

endmodule

`default_nettype wire

@@ rtl/core/ordered_value_list.sv @@
// Top level of the ordered value list: sequencer, cell chain and output register
//
//  channel  | dir | handshake                | payload
//  ---------+-----+--------------------------+------------------------------------------
//  request  | in  | i_s_tvalid / o_s_tready  | tdata value,position; tuser opcode
//  result   | out | o_m_tvalid / i_m_tready  | tdata read_value,entry_count; tuser found,status
//
// Each word is handled in order: the compare is captured in every cell as the word
// is taken, then the first match is resolved along the cell chain and the update committed.
// The chain of DEPTH cells ripples the match flag, which sets the path of the commit step.
// Reset (synchronous, active low) empties the list; no clearing pass is needed.
// A new word is taken while a result waits; a stalled result holds the block in
// its commit cycle until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module ordered_value_list #(
    parameter int DEPTH = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [39:0] i_s_tdata,   // [31:0] value, [39:32] position
    input  wire  [1:0]  i_s_tuser,   // [1:0] opcode
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] read_value, [38:32] entry_count, [39] zero
    output logic [2:0]  o_m_tuser    // [0] found, [2:1] status
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > ovl_pkg::POS_W) ? CW : ovl_pkg::POS_W;

    ovl_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    ovl_pkg::t_opcode r_op;
    logic [ovl_pkg::VALUE_W-1:0] r_value;
    logic [ovl_pkg::POS_W-1:0]   r_pos;

    logic                          r_out_valid;
    logic [ovl_pkg::VALUE_W-1:0]   r_rd, n_rd;
    logic                          r_found, n_found;
    ovl_pkg::t_status              r_status, n_status;
    logic [ovl_pkg::COUNT_W-1:0]   r_cnt_out;

    logic w_accept, w_go, w_ready;
    logic w_empty, w_full, w_any;
    logic [CW-1:0] w_rd_idx;
    logic [ovl_pkg::VALUE_W-1:0] w_bcast;
    logic [ovl_pkg::VALUE_W-1:0] w_rd_bus;

    ovl_pkg::t_cell_ctl            w_ctl     [DEPTH];
    logic [ovl_pkg::VALUE_W-1:0]   w_val     [DEPTH];
    logic [ovl_pkg::VALUE_W-1:0]   w_next    [DEPTH];
    logic [ovl_pkg::VALUE_W-1:0]   w_cell_rd [DEPTH];
    logic [DEPTH:0]                w_hit;

    assign w_accept = i_s_tvalid && w_ready;
    assign w_empty  = (r_count == '0);
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_any    = w_hit[DEPTH];
    assign w_bcast  = (r_state == ovl_pkg::S_IDLE) ? i_s_tdata[31:0] : r_value;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ovl_pkg::S_IDLE: if (w_accept) n_state = ovl_pkg::S_EXEC;
            ovl_pkg::S_EXEC: if (w_go)     n_state = ovl_pkg::S_IDLE;
            default:                       n_state = ovl_pkg::S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_ready = 1'b0;
        w_go    = 1'b0;
        unique case (r_state)
            ovl_pkg::S_IDLE: w_ready = 1'b1;
            ovl_pkg::S_EXEC: w_go    = !r_out_valid || i_m_tready;
            default: begin
                w_ready = 1'b0;
                w_go    = 1'b0;
            end
        endcase
    end

    assign o_s_tready = w_ready;

    // Clamp the read position into the held entries
    always_comb begin
        priority if (r_pos[ovl_pkg::POS_W-1]) begin
            w_rd_idx = '0;
        end else if (PW'(r_pos[ovl_pkg::POS_W-2:0]) >= PW'(r_count)) begin
            w_rd_idx = r_count - CW'(1);
        end else begin
            w_rd_idx = CW'(r_pos[ovl_pkg::POS_W-2:0]);
        end
    end

    // Cell chain
    assign w_hit[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == DEPTH - 1) begin : g_tail
            assign w_next[i] = w_val[i];
        end else begin : g_mid
            assign w_next[i] = w_val[i+1];
        end

        always_comb begin
            w_ctl[i].valid  = (CW'(i) < r_count);
            w_ctl[i].cap    = w_accept;
            w_ctl[i].load   = w_go && (r_op == ovl_pkg::OP_APPEND) && !w_full
                              && (CW'(i) == r_count);
            w_ctl[i].shift  = w_go && (r_op == ovl_pkg::OP_REMOVE) && w_any;
            w_ctl[i].rd_sel = (CW'(i) == w_rd_idx);
        end

        ovl_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl[i]),
            .i_value      (w_bcast),
            .i_next_value (w_next[i]),
            .i_hit        (w_hit[i]),
            .o_value      (w_val[i]),
            .o_rd_value   (w_cell_rd[i]),
            .o_hit        (w_hit[i+1])
        );
    end

    // Gather the selected entry
    always_comb begin
        w_rd_bus = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd_bus = w_rd_bus | w_cell_rd[k];
        end
    end

    // Result and new count per operation
    always_comb begin
        n_rd     = '0;
        n_found  = 1'b0;
        n_status = ovl_pkg::ST_OK;
        n_count  = r_count;
        unique case (r_op)
            ovl_pkg::OP_APPEND: begin
                if (w_full) n_status = ovl_pkg::ST_FULL;
                else        n_count  = r_count + CW'(1);
            end
            ovl_pkg::OP_REMOVE: begin
                priority if (w_empty) begin
                    n_status = ovl_pkg::ST_EMPTY;
                end else if (!w_any) begin
                    n_status = ovl_pkg::ST_NOT_FOUND;
                end else begin
                    n_found = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            ovl_pkg::OP_CONTAINS: begin
                if (w_empty) n_status = ovl_pkg::ST_EMPTY;
                else         n_found  = w_any;
            end
            ovl_pkg::OP_READ: begin
                if (w_empty) n_status = ovl_pkg::ST_EMPTY;
                else         n_rd     = w_rd_bus;
            end
            default: n_status = ovl_pkg::ST_OK;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ovl_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the request word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= ovl_pkg::t_opcode'(i_s_tuser);
            r_value <= i_s_tdata[31:0];
            r_pos   <= i_s_tdata[39:32];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_rd      <= n_rd;
            r_found   <= n_found;
            r_status  <= n_status;
            r_cnt_out <= ovl_pkg::COUNT_W'(n_count);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_cnt_out, r_rd};
    assign o_m_tuser  = {r_status, r_found};

endmodule

`default_nettype wire

@@ rtl/core/ovl_checker.sv @@
// Port-level checks of the ordered value list, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_value_list_assert.svh"

module ovl_port_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_tvalid,
    input wire        o_s_tready,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [39:0] o_m_tdata,
    input wire [2:0]  o_m_tuser
);

    // A taken request word blocks the input for the commit cycle
    `OVL_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "input ready right after a taken word")

    // A stalled result holds
    `OVL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result changed while stalled")

    // An empty-list result reports no entries
    `OVL_ASSERT(a_empty_cnt, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser[2:1] == ovl_pkg::ST_EMPTY) |-> (o_m_tdata[38:32] == '0), "empty status with entries held")

    // A match is only reported with ok status
    `OVL_ASSERT(a_found_ok, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0] |-> (o_m_tuser[2:1] == ovl_pkg::ST_OK), "found with error status")

    // Any error status carries a zero read value
    `OVL_ASSERT(a_err_zero, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser[2:1] != ovl_pkg::ST_OK) |-> (o_m_tdata[31:0] == '0), "read value on error")

endmodule

bind ordered_value_list ovl_port_checker u_ovl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

@@ tb/ovl_checker.sv @@
// Checker for the ordered value list: mirrors the list and compares every result word
`timescale 1ns / 1ps

module ovl_checker #(
    parameter int DEPTH = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [39:0] i_s_tdata,   // [31:0] value, [39:32] position
    input  wire  [1:0]  i_s_tuser,   // [1:0] opcode
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [39:0] i_m_tdata,   // [31:0] read_value, [38:32] entry_count, [39] zero
    input  wire  [2:0]  i_m_tuser,   // [0] found, [2:1] status
    output int          o_fail_count,
    output int          o_replies_owed
);

    typedef struct packed {
        logic signed [ovl_pkg::VALUE_W-1:0] read_value;
        logic                               found;
        ovl_pkg::t_status                   status;
        logic [ovl_pkg::COUNT_W-1:0]        entry_count;
    } t_list_reply;

    // Mirror of the list contents and fill level
    logic signed [ovl_pkg::VALUE_W-1:0] cells [DEPTH];
    int                                 held;
    t_list_reply                        reply_queue [$];

    initial o_fail_count   = 0;
    initial o_replies_owed = 0;
    initial held           = 0;

    // Locate the first held cell equal to v; -1 when there is none
    function automatic int find_first(input logic signed [ovl_pkg::VALUE_W-1:0] v);
        int i;
        for (i = 0; i < held; i++) begin
            if (cells[i] == v)
                return i;
        end
        return -1;
    endfunction

    // Apply one request to the mirror and build the reply it produces
    task automatic apply_list_op(input ovl_pkg::t_opcode op,
                                 input logic signed [ovl_pkg::VALUE_W-1:0] val,
                                 input logic signed [ovl_pkg::POS_W-1:0] pos,
                                 output t_list_reply rep);
        int idx;
        int hit;
        rep.read_value = '0;
        rep.found      = 1'b0;
        rep.status     = ovl_pkg::ST_OK;
        case (op)
            ovl_pkg::OP_APPEND: begin
                if (held >= DEPTH) begin
                    rep.status = ovl_pkg::ST_FULL;
                end else begin
                    cells[held] = val;
                    held++;
                end
            end
            ovl_pkg::OP_REMOVE: begin
                if (held == 0) begin
                    rep.status = ovl_pkg::ST_EMPTY;
                end else begin
                    hit = find_first(val);
                    if (hit < 0) begin
                        rep.status = ovl_pkg::ST_NOT_FOUND;
                    end else begin
                        // close the gap behind the removed cell
                        for (idx = hit; idx < held - 1; idx++)
                            cells[idx] = cells[idx + 1];
                        held--;
                        rep.found = 1'b1;
                    end
                end
            end
            ovl_pkg::OP_CONTAINS: begin
                if (held == 0)
                    rep.status = ovl_pkg::ST_EMPTY;
                else
                    rep.found = (find_first(val) >= 0);
            end
            default: begin
                if (held == 0) begin
                    rep.status = ovl_pkg::ST_EMPTY;
                end else begin
                    // clamp the position to the first or last held cell
                    if (pos < 0)
                        idx = 0;
                    else if (int'(pos) >= held)
                        idx = held - 1;
                    else
                        idx = int'(pos);
                    rep.read_value = cells[idx];
                end
            end
        endcase
        rep.entry_count = held[ovl_pkg::COUNT_W-1:0];
    endtask

    // Compare one field and count a mismatch
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    // Track request words into the mirror, match result words against the oldest reply
    always @(posedge i_clk) begin
        t_list_reply rep;
        if (!i_rst_n) begin
            held = 0;
            reply_queue.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                apply_list_op(ovl_pkg::t_opcode'(i_s_tuser), i_s_tdata[31:0],
                              i_s_tdata[39:32], rep);
                reply_queue.push_back(rep);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (reply_queue.size() == 0) begin
                    $error("result word with no request waiting for it");
                    o_fail_count++;
                end else begin
                    rep = reply_queue.pop_front();
                    check_field("read_value", rep.read_value, i_m_tdata[31:0]);
                    check_field("entry_count", 32'(rep.entry_count),
                                32'(i_m_tdata[38:32]));
                    check_field("tdata pad", 32'd0, 32'(i_m_tdata[39]));
                    check_field("found", 32'(rep.found), 32'(i_m_tuser[0]));
                    check_field("status", 32'(rep.status), 32'(i_m_tuser[2:1]));
                end
            end
        end
        o_replies_owed <= reply_queue.size();
    end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the ordered value list: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

    localparam int LIST_DEPTH   = 64;
    localparam int RANDOM_ITEMS = 1500;
    localparam int PHASE_LEN    = 100;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum int {
        PH_FILL,
        PH_MIXED,
        PH_DRAIN
    } t_phase;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata  = '0;   // [31:0] value, [39:32] position
    logic [1:0]  i_s_tuser  = '0;   // [1:0] opcode
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;         // [31:0] read_value, [38:32] entry_count, [39] zero
    logic [2:0]  o_m_tuser;         // [0] found, [2:1] status

    int          fail_count;
    int          replies_owed;
    int          cycle_cnt  = 0;
    int          rx_cycle   = 0;
    int          hold_left  = 0;
    bit          tx_calm    = 1'b0;
    logic [31:0] value_pool [16];

    ordered_value_list #(.DEPTH(LIST_DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    ovl_checker #(.DEPTH(LIST_DEPTH)) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_tvalid),
        .i_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .i_s_tuser      (i_s_tuser),
        .i_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .i_m_tdata      (o_m_tdata),
        .i_m_tuser      (o_m_tuser),
        .o_fail_count   (fail_count),
        .o_replies_owed (replies_owed)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: random stalls, a calm stretch, and two long hold-offs to back up the block
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (rx_cycle == 1500 || rx_cycle == 3500) begin
            hold_left  <= 150;
            i_m_tready <= 1'b0;
        end else if (rx_cycle >= 2400 && rx_cycle < 3200) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= 12);
        end
    end

    // Abort a hung run
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one request word and hold it until the block takes it
    task automatic offer_request(input ovl_pkg::t_opcode op, input logic [31:0] val,
                                 input logic [7:0] pos);
        while (!tx_calm && $urandom_range(0, 99) < 12) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {pos, val};
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
    endtask

    // Draw a value, mostly from a small pool so that searches and removals hit
    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    // Draw an opcode weighted toward the current phase
    function automatic ovl_pkg::t_opcode pick_opcode(input t_phase ph);
        int roll;
        roll = $urandom_range(0, 99);
        case (ph)
            PH_FILL:
                return roll < 80 ? ovl_pkg::OP_APPEND : roll < 87 ? ovl_pkg::OP_READ :
                       roll < 94 ? ovl_pkg::OP_CONTAINS : ovl_pkg::OP_REMOVE;
            PH_DRAIN:
                return roll < 60 ? ovl_pkg::OP_REMOVE : roll < 75 ? ovl_pkg::OP_READ :
                       roll < 90 ? ovl_pkg::OP_CONTAINS : ovl_pkg::OP_APPEND;
            default:
                return ovl_pkg::t_opcode'(roll % 4);
        endcase
    endfunction

    initial begin
        int     n;
        t_phase ph;
        logic [7:0] pos;

        foreach (value_pool[k])
            value_pool[k] = $urandom;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list: read, remove and contains all report empty
        offer_request(ovl_pkg::OP_READ, 32'd0, 8'd0);
        offer_request(ovl_pkg::OP_REMOVE, 32'd5, 8'd0);
        offer_request(ovl_pkg::OP_CONTAINS, 32'd5, 8'd0);
        // Extreme values, with a duplicate of the largest
        offer_request(ovl_pkg::OP_APPEND, 32'h7fff_ffff, 8'd0);
        offer_request(ovl_pkg::OP_APPEND, 32'h8000_0000, 8'd0);
        offer_request(ovl_pkg::OP_APPEND, 32'h0000_0000, 8'd0);
        offer_request(ovl_pkg::OP_APPEND, 32'hffff_ffff, 8'd0);
        offer_request(ovl_pkg::OP_APPEND, 32'h7fff_ffff, 8'd0);
        // Hit and miss on a list that holds entries
        offer_request(ovl_pkg::OP_CONTAINS, 32'h8000_0000, 8'd0);
        offer_request(ovl_pkg::OP_CONTAINS, 32'd12345, 8'd0);
        // Positions: most negative, largest, in range, equal to the count
        offer_request(ovl_pkg::OP_READ, 32'd0, 8'h80);
        offer_request(ovl_pkg::OP_READ, 32'd0, 8'h7f);
        offer_request(ovl_pkg::OP_READ, 32'd0, 8'd2);
        offer_request(ovl_pkg::OP_READ, 32'd0, 8'd5);
        // Remove the first of two equal entries, then a miss, then the rest
        offer_request(ovl_pkg::OP_REMOVE, 32'h7fff_ffff, 8'd0);
        offer_request(ovl_pkg::OP_READ, 32'd0, 8'd0);
        offer_request(ovl_pkg::OP_REMOVE, 32'd12345, 8'd0);
        offer_request(ovl_pkg::OP_REMOVE, 32'h0000_0000, 8'd0);
        offer_request(ovl_pkg::OP_REMOVE, 32'hffff_ffff, 8'd0);
        offer_request(ovl_pkg::OP_REMOVE, 32'h8000_0000, 8'd0);
        offer_request(ovl_pkg::OP_REMOVE, 32'h7fff_ffff, 8'd0);
        offer_request(ovl_pkg::OP_READ, 32'd0, 8'hff);

        // Random phases: fill to full, mix, drain
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            ph      = t_phase'((n / PHASE_LEN) % 3);
            tx_calm = (n >= 700 && n < 900);
            if ($urandom_range(0, 3) == 0)
                pos = 8'($urandom);
            else
                pos = 8'($urandom_range(0, 70));
            offer_request(pick_opcode(ph), pick_value(), pos);
        end
        i_s_tvalid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        do
            @(posedge i_clk);
        while (replies_owed != 0);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
